// ===== rtl/tbo_pkg.sv =====
// Shared types and constants for the triangle/box overlap block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tbo_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   // box corner: coordinate plus unsigned size, one bit wider
   localparam int PT_BITS    = COORD_BITS + 1;
   // corner minus vertex
   localparam int DIFF_BITS  = PT_BITS + 1;
   // vertex minus vertex
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = EDGE_BITS + DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   localparam int NUM_VERTS  = 3;
   localparam int CSR_IDX_BITS = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [SIZE_BITS-1:0]  size_type;
   typedef logic signed [PT_BITS-1:0]    point_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   // index 0 left, 1 right, 2 top
   typedef vertex_type [NUM_VERTS-1:0] tri_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_LEFT_X  = 3'd0,
      REG_LEFT_Y  = 3'd1,
      REG_RIGHT_X = 3'd2,
      REG_RIGHT_Y = 3'd3,
      REG_TOP_X   = 3'd4,
      REG_TOP_Y   = 3'd5
   } reg_idx_type;

endpackage

// ===== rtl/tbo_csr.sv =====
// Vertex register file for the triangle/box overlap block.
// Depends on tbo_pkg.
`timescale 1ns / 1ps

module tbo_csr import tbo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_data,
   output tri_type                 tri_verts
);

   tri_type tri_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx_type'(csr_index))
            REG_LEFT_X:  tri_ff[0].x <= csr_data;
            REG_LEFT_Y:  tri_ff[0].y <= csr_data;
            REG_RIGHT_X: tri_ff[1].x <= csr_data;
            REG_RIGHT_Y: tri_ff[1].y <= csr_data;
            REG_TOP_X:   tri_ff[2].x <= csr_data;
            REG_TOP_Y:   tri_ff[2].y <= csr_data;
            default: begin
               // unused indexes are dropped
            end
         endcase
      end
   end

   assign tri_verts = tri_ff;

endmodule

// ===== rtl/tbo_corner.sv =====
// One box corner against the three triangle edges: difference, multiply and
// sign stages. Three register stages, no control. Depends on tbo_pkg.
`timescale 1ns / 1ps

module tbo_corner import tbo_pkg::*; (
   input  logic      clock,
   input  point_type pt_x,
   input  point_type pt_y,
   input  tri_type   tri_verts,
   output logic      in_tri
);

   logic signed [EDGE_BITS-1:0] ex_ff [NUM_VERTS];
   logic signed [EDGE_BITS-1:0] ey_ff [NUM_VERTS];
   logic signed [DIFF_BITS-1:0] dx_ff [NUM_VERTS];
   logic signed [DIFF_BITS-1:0] dy_ff [NUM_VERTS];
   logic signed [PROD_BITS-1:0] p1_ff [NUM_VERTS];
   logic signed [PROD_BITS-1:0] p2_ff [NUM_VERTS];
   logic [NUM_VERTS-1:0]        pos_ff;
   logic [NUM_VERTS-1:0]        neg_ff;

   for (genvar i = 0; i < NUM_VERTS; i++) begin : g_edge
      localparam int NXT = (i + 1) % NUM_VERTS;

      logic signed [EDGE_BITS-1:0]  ex_in, ey_in;
      logic signed [DIFF_BITS-1:0]  dx_in, dy_in;
      logic signed [PROD_BITS-1:0]  p1_in, p2_in;
      logic signed [CROSS_BITS-1:0] cross_prod;

      // edge vector a->b and corner offset p-a
      assign ex_in = EDGE_BITS'($signed(tri_verts[NXT].x))
                   - EDGE_BITS'($signed(tri_verts[i].x));
      assign ey_in = EDGE_BITS'($signed(tri_verts[NXT].y))
                   - EDGE_BITS'($signed(tri_verts[i].y));
      assign dx_in = DIFF_BITS'(pt_x) - DIFF_BITS'($signed(tri_verts[i].x));
      assign dy_in = DIFF_BITS'(pt_y) - DIFF_BITS'($signed(tri_verts[i].y));

      assign p1_in = PROD_BITS'(ex_ff[i]) * PROD_BITS'(dy_ff[i]);
      assign p2_in = PROD_BITS'(ey_ff[i]) * PROD_BITS'(dx_ff[i]);

      assign cross_prod = CROSS_BITS'(p1_ff[i]) - CROSS_BITS'(p2_ff[i]);

      always_ff @(posedge clock) begin
         ex_ff[i]  <= ex_in;
         ey_ff[i]  <= ey_in;
         dx_ff[i]  <= dx_in;
         dy_ff[i]  <= dy_in;
         p1_ff[i]  <= p1_in;
         p2_ff[i]  <= p2_in;
         pos_ff[i] <= !cross_prod[CROSS_BITS-1] && (cross_prod != '0);
         neg_ff[i] <= cross_prod[CROSS_BITS-1];
      end
   end

   // strictly inside for either winding
   assign in_tri = (&pos_ff) | (&neg_ff);

endmodule

// ===== rtl/triangle_box_overlap.sv =====
// Top level of the triangle/box overlap block: input stage, four corner
// units, vertex-in-box check and result register. Depends on tbo_pkg,
// tbo_csr and tbo_corner.
`timescale 1ns / 1ps

// Overlap of an axis-aligned box with a triangle held in six vertex
// registers. A box item is taken on every cycle in which start is high;
// busy is always low. Each item gives one result, rsp_valid high for one
// cycle with rsp_overlap, in item order; results cannot be held off. Each
// item passes through the input register, edge differences, multipliers,
// cross-product sign, and the final combine. Vertex registers are written
// through csr_write with no wait; write them only while no item is in flight.
module triangle_box_overlap import tbo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  coord_type               req_box_left,
   input  coord_type               req_box_top,
   input  size_type                req_box_width,
   input  size_type                req_box_height,
   output logic                    rsp_valid,
   output logic                    rsp_overlap,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_data
);

   localparam int NUM_CORNERS = 4;
   localparam int LAT = 4;

   tri_type tri_verts;

   tbo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .tri_verts (tri_verts)
   );

   // stage 1: box registers
   coord_type left_ff, top_ff;
   size_type  width_ff, height_ff;
   logic [LAT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      left_ff   <= req_box_left;
      top_ff    <= req_box_top;
      width_ff  <= req_box_width;
      height_ff <= req_box_height;
   end

   point_type l_pt, t_pt, r_pt, b_pt;

   assign l_pt = PT_BITS'(left_ff);
   assign t_pt = PT_BITS'(top_ff);
   assign r_pt = l_pt + point_type'({1'b0, 1'b0, width_ff});
   assign b_pt = t_pt + point_type'({1'b0, 1'b0, height_ff});

   // four corner units, stages 2 to 4
   logic [NUM_CORNERS-1:0] corner_hit;

   tbo_corner u_corner_lt (
      .clock(clock), .pt_x(l_pt), .pt_y(t_pt), .tri_verts(tri_verts),
      .in_tri(corner_hit[0])
   );
   tbo_corner u_corner_rt (
      .clock(clock), .pt_x(r_pt), .pt_y(t_pt), .tri_verts(tri_verts),
      .in_tri(corner_hit[1])
   );
   tbo_corner u_corner_lb (
      .clock(clock), .pt_x(l_pt), .pt_y(b_pt), .tri_verts(tri_verts),
      .in_tri(corner_hit[2])
   );
   tbo_corner u_corner_rb (
      .clock(clock), .pt_x(r_pt), .pt_y(b_pt), .tri_verts(tri_verts),
      .in_tri(corner_hit[3])
   );

   // vertex in half-open box, stage 2, then delayed to line up with corners
   logic [NUM_VERTS-1:0] vin_in;
   logic vbox_s2_ff, vbox_s3_ff, vbox_s4_ff;

   for (genvar i = 0; i < NUM_VERTS; i++) begin : g_vbox
      point_type vx, vy;
      assign vx = PT_BITS'($signed(tri_verts[i].x));
      assign vy = PT_BITS'($signed(tri_verts[i].y));
      assign vin_in[i] = (l_pt <= vx) && (vx < r_pt) && (t_pt <= vy) && (vy < b_pt);
   end

   always_ff @(posedge clock) begin
      vbox_s2_ff <= |vin_in;
      vbox_s3_ff <= vbox_s2_ff;
      vbox_s4_ff <= vbox_s3_ff;
   end

   // stage 5: result register
   logic overlap_ff, rsp_valid_ff;

   always_ff @(posedge clock) begin
      overlap_ff <= (|corner_hit) | vbox_s4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[LAT-2:0], start};
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   assign busy        = 1'b0;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = overlap_ff;

endmodule
